@@ rtl/fppq_pkg.sv @@
package fppq_pkg;

  // Default build constants
  localparam int unsigned PeriodDivisorDef = 4;
  localparam int unsigned TimerTurnDef     = 65536;
  localparam int unsigned PinSamplesDef    = 4;

  // Saturated overflow count
  localparam logic [7:0] SatOvf = 8'hFF;

  // Input item commands
  typedef enum logic [2:0] {
    CMD_CAPTURE    = 3'd0,
    CMD_SET_COUNT  = 3'd1,
    CMD_CLR_LOW    = 3'd2,
    CMD_CLR_HIGH   = 3'd3,
    CMD_CLR_BOTH   = 3'd4,
    CMD_ENABLE     = 3'd5,
    CMD_DISABLE    = 3'd6
  } fppq_cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MAX_PERIOD  = 3'd0,
    CFG_MIN_PERIOD  = 3'd1,
    CFG_CORR_PERIOD = 3'd2,
    CFG_CORR_FACTOR = 3'd3,
    CFG_HIGH_FILTER = 3'd4,
    CFG_LOW_FILTER  = 3'd5
  } fppq_cfg_idx_e;

  // Configuration reset values
  localparam logic [15:0] MaxPeriodRst  = 16'hFFFF;
  localparam logic [15:0] MinPeriodRst  = 16'h0000;
  localparam logic [15:0] CorrPeriodRst = 16'hFFFF;
  localparam logic [7:0]  CorrFactorRst = 8'd0;
  localparam logic [7:0]  HighFilterRst = 8'd3;
  localparam logic [7:0]  LowFilterRst  = 8'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] capture_time;
    logic [7:0]  overflow_count;
    logic        overflow_pending;
    logic [3:0]  high_samples;
    logic [15:0] count_value;
  } fppq_in_t;

  typedef struct packed {
    logic [15:0] pulse_count;
    logic        warn_high;
    logic        warn_low;
    logic        edge_is_rising;
  } fppq_out_t;

  typedef struct packed {
    logic [15:0] max_period;
    logic [15:0] min_period;
    logic [15:0] corr_period;
    logic [7:0]  corr_factor;
    logic [7:0]  high_filter;
    logic [7:0]  low_filter;
  } fppq_cfg_t;

endpackage

@@ rtl/fppq_cfg.sv @@
module fppq_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [15:0]       wr_data,
  output fppq_pkg::fppq_cfg_t cfg
);
  import fppq_pkg::*;

  fppq_cfg_t cfg_r;
  fppq_cfg_t cfg_nxt;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_MAX_PERIOD:  cfg_nxt.max_period  = wr_data;
        CFG_MIN_PERIOD:  cfg_nxt.min_period  = wr_data;
        CFG_CORR_PERIOD: cfg_nxt.corr_period = wr_data;
        CFG_CORR_FACTOR: cfg_nxt.corr_factor = wr_data[7:0];
        CFG_HIGH_FILTER: cfg_nxt.high_filter = wr_data[7:0];
        CFG_LOW_FILTER:  cfg_nxt.low_filter  = wr_data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_period  <= MaxPeriodRst;
      cfg_r.min_period  <= MinPeriodRst;
      cfg_r.corr_period <= CorrPeriodRst;
      cfg_r.corr_factor <= CorrFactorRst;
      cfg_r.high_filter <= HighFilterRst;
      cfg_r.low_filter  <= LowFilterRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/fppq_core.sv @@
module fppq_core #(
  parameter int unsigned PERIOD_DIVISOR = fppq_pkg::PeriodDivisorDef,
  parameter int unsigned TIMER_TURN     = fppq_pkg::TimerTurnDef,
  parameter int unsigned PIN_SAMPLES    = fppq_pkg::PinSamplesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  fppq_pkg::fppq_in_t  item,
  input  fppq_pkg::fppq_cfg_t cfg,
  output fppq_pkg::fppq_out_t res
);
  import fppq_pkg::*;

  // Reciprocal constants for the exact divide of a 32-bit tick count
  localparam int unsigned DivShift  = $clog2(PERIOD_DIVISOR);
  localparam logic [63:0] DivMulW   =
    ((64'd1 << 32) * ((64'd1 << DivShift) - 64'(PERIOD_DIVISOR))) / 64'(PERIOD_DIVISOR)
    + 64'd1;
  localparam logic [31:0] DivMul    = DivMulW[31:0];
  localparam int unsigned Sh1       = (DivShift > 0) ? 1 : 0;
  localparam int unsigned Sh2       = (DivShift > 0) ? DivShift - 1 : 0;
  localparam logic [31:0] Turn32    = 32'(TIMER_TURN);
  localparam logic [16:0] HalfTurn  = 17'(TIMER_TURN / 2);
  localparam logic [7:0]  MaxOvf    = 8'(PERIOD_DIVISOR - 1);
  localparam logic [3:0]  AllHigh   = 4'(PIN_SAMPLES);

  logic [15:0] count_r, count_nxt;
  logic [15:0] last_r, last_nxt;
  logic [7:0]  high_run_r, high_run_nxt;
  logic [7:0]  low_run_r, low_run_nxt;
  logic [7:0]  corr_run_r, corr_run_nxt;
  logic        high_flag_r, high_flag_nxt;
  logic        low_flag_r, low_flag_nxt;
  logic        fix_due_r, fix_due_nxt;
  logic        rising_r, rising_nxt;
  logic        enabled_r, enabled_nxt;

  logic        race;
  logic [7:0]  ovf_adj;
  logic        fix_adj;
  logic [31:0] ticks;
  logic [63:0] prod;
  logic [31:0] t1;
  logic [32:0] qsum;
  logic [15:0] period;
  logic        too_slow_ovf;
  logic [7:0]  corr_inc;

  // Fold a racing timer overflow into the capture's overflow count, or take back one folded in before
  always_comb begin
    race    = item.overflow_pending && ({1'b0, item.capture_time} < HalfTurn);
    ovf_adj = item.overflow_count;
    fix_adj = fix_due_r;
    if (race) begin
      if (!fix_due_r && (item.overflow_count < SatOvf)) begin
        ovf_adj = item.overflow_count + 8'd1;
        fix_adj = 1'b1;
      end
    end else if (fix_due_r) begin
      ovf_adj = item.overflow_count - 8'd1;
      fix_adj = 1'b0;
    end
  end

  // Measure the period and divide by reciprocal multiplication
  always_comb begin
    too_slow_ovf = (ovf_adj >= SatOvf) || (ovf_adj > MaxOvf);
    ticks  = 32'(ovf_adj) * Turn32 + 32'(item.capture_time) - 32'(last_r);
    prod   = 64'(ticks) * 64'(DivMul);
    t1     = prod[63:32];
    qsum   = {1'b0, t1} + 33'((ticks - t1) >> Sh1);
    qsum   = qsum >> Sh2;
    period = qsum[15:0];
  end

  assign corr_inc = corr_run_r + 8'd1;

  // Next state for one item
  always_comb begin
    count_nxt     = count_r;
    last_nxt      = last_r;
    high_run_nxt  = high_run_r;
    low_run_nxt   = low_run_r;
    corr_run_nxt  = corr_run_r;
    high_flag_nxt = high_flag_r;
    low_flag_nxt  = low_flag_r;
    fix_due_nxt   = fix_due_r;
    rising_nxt    = rising_r;
    enabled_nxt   = enabled_r;
    unique case (item.command)
      CMD_CAPTURE: begin
        if (enabled_r) begin
          if (rising_r) begin
            if (item.high_samples == AllHigh) begin
              fix_due_nxt = fix_adj;
              rising_nxt  = 1'b0;
              last_nxt    = item.capture_time;
              if (too_slow_ovf) begin
                // Too many overflows, too slow without a period
                if (low_run_r < cfg.low_filter) low_run_nxt = low_run_r + 8'd1;
                else low_flag_nxt = 1'b1;
              end else if (period < cfg.min_period) begin
                // Too fast
                if (high_run_r < cfg.high_filter) high_run_nxt = high_run_r + 8'd1;
                else high_flag_nxt = 1'b1;
              end else if (period > cfg.max_period) begin
                // Too slow
                if (low_run_r < cfg.low_filter) low_run_nxt = low_run_r + 8'd1;
                else low_flag_nxt = 1'b1;
              end else begin
                // Clean pulse, plus correction count
                high_run_nxt = 8'd0;
                low_run_nxt  = 8'd0;
                count_nxt    = count_r + 16'((high_run_r == 8'd0) && (low_run_r == 8'd0));
                if (period >= cfg.corr_period) begin
                  if (corr_inc >= cfg.corr_factor) begin
                    corr_run_nxt = 8'd0;
                    count_nxt    = count_nxt + 16'd1;
                  end else begin
                    corr_run_nxt = corr_inc;
                  end
                end else begin
                  corr_run_nxt = 8'd0;
                end
              end
            end
          end else if (item.high_samples == 4'd0) begin
            rising_nxt = 1'b1;
          end
        end
      end
      CMD_SET_COUNT: count_nxt = item.count_value;
      CMD_CLR_LOW: begin
        low_run_nxt  = 8'd0;
        low_flag_nxt = 1'b0;
      end
      CMD_CLR_HIGH: begin
        high_run_nxt  = 8'd0;
        high_flag_nxt = 1'b0;
      end
      CMD_CLR_BOTH: begin
        low_run_nxt   = 8'd0;
        low_flag_nxt  = 1'b0;
        high_run_nxt  = 8'd0;
        high_flag_nxt = 1'b0;
      end
      CMD_ENABLE: begin
        if (!enabled_r) begin
          rising_nxt  = 1'b1;
          enabled_nxt = 1'b1;
        end
      end
      CMD_DISABLE: enabled_nxt = 1'b0;
      default: ;
    endcase
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 16'd0;
      last_r      <= 16'd0;
      high_run_r  <= 8'd0;
      low_run_r   <= 8'd0;
      corr_run_r  <= 8'd0;
      high_flag_r <= 1'b0;
      low_flag_r  <= 1'b0;
      fix_due_r   <= 1'b0;
      rising_r    <= 1'b1;
      enabled_r   <= 1'b0;
    end else if (fire) begin
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      high_run_r  <= high_run_nxt;
      low_run_r   <= low_run_nxt;
      corr_run_r  <= corr_run_nxt;
      high_flag_r <= high_flag_nxt;
      low_flag_r  <= low_flag_nxt;
      fix_due_r   <= fix_due_nxt;
      rising_r    <= rising_nxt;
      enabled_r   <= enabled_nxt;
    end
  end

  assign res.pulse_count    = count_nxt;
  assign res.warn_high      = high_flag_nxt;
  assign res.warn_low       = low_flag_nxt;
  assign res.edge_is_rising = rising_nxt;

endmodule

@@ rtl/flow_pulse_period_qualifier.sv @@
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_data  (fppq_in_t)
// out      out_valid / out_stall  out_data (fppq_out_t)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item waits
// in the input register; its result then goes to the result register.
// Rate is set by the combinational state update between the two registers.
// Synchronous active-low reset clears the pipeline and the qualifier state.
// out_stall holds a shown result and any queued item; in_stall rises
// only while a held input item cannot move on. cfg_ready is always high.
module flow_pulse_period_qualifier #(
  parameter int unsigned PERIOD_DIVISOR = fppq_pkg::PeriodDivisorDef,
  parameter int unsigned TIMER_TURN     = fppq_pkg::TimerTurnDef,
  parameter int unsigned PIN_SAMPLES    = fppq_pkg::PinSamplesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fppq_pkg::fppq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fppq_pkg::fppq_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import fppq_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  fppq_in_t   s1_data_r;
  logic       out_valid_r, out_valid_nxt;
  fppq_out_t  out_data_r;
  logic       out_free;
  logic       fire;
  fppq_cfg_t  cfg;
  fppq_out_t  res;

  assign cfg_ready = 1'b1;

  fppq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fppq_core #(
    .PERIOD_DIVISOR (PERIOD_DIVISOR),
    .TIMER_TURN     (TIMER_TURN),
    .PIN_SAMPLES    (PIN_SAMPLES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Advance the pipeline when the result register is free
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("item moved but no result shown");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !fire |=> s1_valid_r && $stable(s1_data_r))
    else $error("held item lost or changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

endmodule
